// File: hdl/pfe_pkg.sv
// Package: widths, codes and operand counts for the postfix evaluator.
package pfe_pkg;

  localparam int StackDepth = 16;
  localparam int ValueWidth = 32;
  localparam int PtrW       = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);
  localparam int ShW        = $clog2(ValueWidth);
  localparam int DivCntW    = $clog2(ValueWidth + 1);

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [CntW-1:0]       cnt_t;
  typedef logic [PtrW-1:0]       ptr_t;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_OP   = 2'd1,
    CMD_END  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    OP_NEG    = 5'd0,  OP_BITNOT = 5'd1,  OP_LOGNOT = 5'd2,  OP_MUL    = 5'd3,
    OP_DIV    = 5'd4,  OP_MOD    = 5'd5,  OP_ADD    = 5'd6,  OP_SUB    = 5'd7,
    OP_SHL    = 5'd8,  OP_SHR    = 5'd9,  OP_GE     = 5'd10, OP_GT     = 5'd11,
    OP_LE     = 5'd12, OP_LT     = 5'd13, OP_EQ     = 5'd14, OP_NE     = 5'd15,
    OP_AND    = 5'd16, OP_XOR    = 5'd17, OP_OR     = 5'd18, OP_LOGAND = 5'd19,
    OP_LOGOR  = 5'd20, OP_TERTIF = 5'd21, OP_TERTELSE = 5'd22, OP_PLUS = 5'd23
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FEW    = 3'd1,
    ST_DIVZ   = 3'd2,
    ST_MODZ   = 3'd3,
    ST_TERN   = 3'd4,
    ST_SINGLE = 3'd5,
    ST_OVER   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP1,
    S_POP2,
    S_POP3,
    S_DIV,
    S_RESULT,
    S_RDEND,
    S_OUT
  } state_t;

  // Divider handshake.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic [1:0] op_args(input logic [4:0] op);
    logic [1:0] n;
    n = 2'd2;
    if (op == OP_NEG || op == OP_BITNOT || op == OP_LOGNOT || op == OP_PLUS) begin
      n = 2'd1;
    end else if (op == OP_TERTIF) begin
      n = 2'd0;
    end else if (op == OP_TERTELSE) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

// File: hdl/pfe_ram.sv
// Generic single-port RAM with registered read.
module pfe_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: hdl/pfe_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module pfe_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pfe_pkg::value_t   dividend,
  input  pfe_pkg::value_t   divisor,
  output pfe_pkg::div_ctl_t ctl,
  output pfe_pkg::value_t   quotient,
  output pfe_pkg::value_t   remainder
);
  import pfe_pkg::*;

  value_t                 q_r, r_r, d_r;
  logic [DivCntW-1:0]     cnt_r;
  logic                   busy_r, done_r;
  logic [ValueWidth:0]    trial;

  assign trial = {r_r, q_r[ValueWidth-1]} - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DivCntW'(ValueWidth);
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
      end else if (busy_r) begin
        if (trial[ValueWidth]) begin
          r_r <= {r_r[ValueWidth-2:0], q_r[ValueWidth-1]};
          q_r <= {q_r[ValueWidth-2:0], 1'b0};
        end else begin
          r_r <= trial[ValueWidth-1:0];
          q_r <= {q_r[ValueWidth-2:0], 1'b1};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DivCntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;
endmodule

// File: hdl/postfix_expression_evaluator.sv
// Top level: postfix evaluator on a RAM-held value stack.
// Takes push, operator and end words one at a time. A push is written in its
// accept cycle, so the next word can follow at once. An operator is accepted,
// pops its operands in S_POP1, S_POP2 and S_POP3 as it needs them (one stack
// RAM read each) and writes the result in S_RESULT; divide and modulo first
// run the bit-serial divider in S_DIV (start, 32 quotient bits, done), or go
// back to idle from S_POP2 when the divisor is zero. An end word reads the
// bottom entry, S_RDEND registers the result, and it stays in the output
// register, with the input held off, until taken. The stack has no clearing
// pass; only entries below the count are used.
module postfix_expression_evaluator (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_cmd,
  input  pfe_pkg::value_t in_value,
  input  logic [4:0]      in_op,
  output logic            out_valid,
  input  logic            out_ready,
  output pfe_pkg::value_t out_result_value,
  output logic [2:0]      out_status
);
  import pfe_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  logic [2:0] err_r, err_nxt;
  logic   tern_r, tern_nxt;
  logic [4:0] op_r, op_nxt;
  value_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  value_t res_r, res_nxt;
  logic [2:0] st_r, st_nxt;

  logic   we;
  ptr_t   addr;
  value_t wdata, rdata;
  logic   div_start;
  div_ctl_t div_ctl;
  value_t quo, rem;
  value_t alu;

  pfe_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_stack (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  pfe_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_r), .divisor(b_r),
    .ctl(div_ctl), .quotient(quo), .remainder(rem)
  );

  // Result of the operator on latched operands.
  always_comb begin
    alu = b_r;
    case (op_r)
      OP_NEG:    alu = '0 - b_r;
      OP_BITNOT: alu = ~b_r;
      OP_LOGNOT: alu = value_t'(b_r == '0);
      OP_MUL:    alu = a_r * b_r;
      OP_DIV:    alu = quo;
      OP_MOD:    alu = rem;
      OP_ADD:    alu = a_r + b_r;
      OP_SUB:    alu = a_r - b_r;
      OP_SHL:    alu = (b_r >= value_t'(ValueWidth)) ? '0 : a_r << b_r[ShW-1:0];
      OP_SHR:    alu = (b_r >= value_t'(ValueWidth)) ? '0 : a_r >> b_r[ShW-1:0];
      OP_GE:     alu = value_t'(a_r >= b_r);
      OP_GT:     alu = value_t'(a_r > b_r);
      OP_LE:     alu = value_t'(a_r <= b_r);
      OP_LT:     alu = value_t'(a_r < b_r);
      OP_EQ:     alu = value_t'(a_r == b_r);
      OP_NE:     alu = value_t'(a_r != b_r);
      OP_AND:    alu = a_r & b_r;
      OP_XOR:    alu = a_r ^ b_r;
      OP_OR:     alu = a_r | b_r;
      OP_LOGAND: alu = value_t'(a_r != '0 && b_r != '0);
      OP_LOGOR:  alu = value_t'(a_r != '0 || b_r != '0);
      OP_TERTELSE: alu = (c_r != '0) ? a_r : b_r;
      default:   alu = b_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= ST_OK;
      tern_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      tern_r  <= tern_nxt;
    end
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    res_r <= res_nxt;
    st_r  <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    tern_nxt  = tern_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    we        = 1'b0;
    addr      = cnt_r[PtrW-1:0];
    wdata     = in_value;
    div_start = 1'b0;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          case (in_cmd)
            CMD_END: begin
              addr = '0;
              state_nxt = S_RDEND;
            end
            CMD_NONE: ;
            default: begin
              if (tern_r) begin
                // Only a tern_if may follow tern_else.
                tern_nxt = 1'b0;
                if (!(in_cmd == CMD_OP && in_op == OP_TERTIF) && err_r == ST_OK) begin
                  err_nxt = ST_TERN;
                end
              end else if (err_r != ST_OK) begin
                // drop until end
              end else if (in_cmd == CMD_PUSH) begin
                if (cnt_r >= cnt_t'(StackDepth)) begin
                  err_nxt = ST_OVER;
                end else begin
                  we = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end
              end else if (in_op > OP_PLUS) begin
                // unknown code: ignore
              end else if (in_op == OP_TERTIF) begin
                err_nxt = ST_TERN;
              end else if (cnt_r < cnt_t'(op_args(in_op))) begin
                err_nxt = ST_FEW;
              end else begin
                addr = PtrW'(cnt_r - 1'b1);
                cnt_nxt = cnt_r - 1'b1;
                state_nxt = S_POP1;
              end
            end
          endcase
        end
      end
      S_POP1: begin
        b_nxt = rdata;
        if (op_args(op_r) == 2'd1) begin
          state_nxt = S_RESULT;
        end else begin
          addr = PtrW'(cnt_r - 1'b1);
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_POP2;
        end
      end
      S_POP2: begin
        a_nxt = rdata;
        if (op_args(op_r) == 2'd3) begin
          addr = PtrW'(cnt_r - 1'b1);
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_POP3;
        end else if (op_r == OP_DIV || op_r == OP_MOD) begin
          if (b_r == '0) begin
            // Popped operands are lost, as in the stack model.
            err_nxt = (op_r == OP_DIV) ? ST_DIVZ : ST_MODZ;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DIV;
          end
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_POP3: begin
        c_nxt = rdata;
        tern_nxt = 1'b1;
        state_nxt = S_RESULT;
      end
      S_DIV: begin
        div_start = !div_ctl.busy && !div_ctl.done;
        if (div_ctl.done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        we = 1'b1;
        wdata = alu;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_RDEND: begin
        if (err_r != ST_OK) begin
          st_nxt = err_r;
        end else if (tern_r) begin
          st_nxt = ST_TERN;
        end else if (cnt_r != cnt_t'(1)) begin
          st_nxt = ST_SINGLE;
        end else begin
          st_nxt = ST_OK;
        end
        res_nxt = (st_nxt == ST_OK) ? rdata : '0;
        cnt_nxt = '0;
        err_nxt = ST_OK;
        tern_nxt = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_result_value = res_r;
  assign out_status       = st_r;
endmodule

// File: hdl/pfe_checker.sv
// Port-level assertions for the postfix evaluator, bound to the top level.
module pfe_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic [2:0]  out_status
);
  import pfe_pkg::*;

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value)
    && $stable(out_status)) else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_OVER) else $error("bad status");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_value == '0)
    else $error("nonzero value with error");

  a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_END |=> ##1 out_valid)
    else $error("end word gave no result");
endmodule

bind postfix_expression_evaluator pfe_port_checks u_pfe_port_checks (.*);
